// File: rtl/core/ffha_pkg.sv
// Shared types, constants and helpers of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

    // Heap size and the span that 16-bit payload offsets can reach.
    localparam int HEAP_WORDS = 16384;
    localparam int SPAN_WORDS = (HEAP_WORDS < 16384) ? HEAP_WORDS : 16384;
    localparam int SPAN_AW    = $clog2(SPAN_WORDS);
    localparam int FILL_W     = SPAN_AW + 1;
    localparam int HEAD_W     = 15;
    localparam int USED_W     = 17;

    localparam logic [33:0] SPAN_BYTES = 34'(SPAN_WORDS * 4);
    localparam logic [31:0] INIT_TAG   = 32'(SPAN_WORDS * 4 - 8);
    localparam logic [31:0] TAG_BYTES  = 32'd8;
    localparam logic [33:0] SPLIT_MIN  = 34'd16;

    // Request operation codes.
    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_FREE    = 3'd1,
        OP_REALLOC = 3'd2,
        OP_CALLOC  = 3'd3,
        OP_LOAD    = 3'd4,
        OP_STORE   = 3'd5
    } t_op;

    // Classified request handed from the front end to the execution engine.
    typedef struct packed {
        t_op         op;
        logic [31:0] n;
        logic [32:0] need;
        logic        n_zero;
        logic        ovf;
        logic [15:0] addr;
        logic        present;
        logic [31:0] wdata;
    } t_cmd;

    // Execution engine states.
    typedef enum logic [5:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_LOAD1,
        ST_A_START, ST_A_RDH, ST_A_CHK, ST_A_NXT,
        ST_PLACE, ST_PLACE2, ST_PLACE3, ST_POST,
        ST_PT0, ST_PT1,
        ST_LD0, ST_LD1, ST_LD2, ST_LD3,
        ST_LA0, ST_LA1, ST_LA2,
        ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_R5B,
        ST_R6, ST_R7, ST_R8, ST_R8B, ST_R9, ST_R10,
        ST_Z0, ST_Z1, ST_Z2, ST_Z3,
        ST_F0, ST_F1, ST_F2, ST_FP0, ST_FP1, ST_FP2, ST_FEND,
        ST_FINISH
    } t_bstate;

    // True when a byte offset falls on a word that exists.
    function automatic logic in_span(input logic [31:0] b);
        return b[31:2] < 30'(SPAN_WORDS);
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/ffha_req_if.sv
// Request channel of the heap allocator.
`default_nettype none
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] byte_count;
    logic [31:0] element_count;
    logic [15:0] address;
    logic        address_present;
    logic [31:0] write_data;

    modport source (output valid, opcode, byte_count, element_count, address,
                    address_present, write_data, input ready);
    modport sink (input valid, opcode, byte_count, element_count, address,
                  address_present, write_data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ffha_rsp_if.sv
// Response channel of the heap allocator.
`default_nettype none
interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_address;
    logic        success;
    logic [31:0] read_data;
    logic [16:0] bytes_in_use;

    modport source (output valid, result_address, success, read_data, bytes_in_use,
                    input ready);
    modport sink (input valid, result_address, success, read_data, bytes_in_use,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/core/ffha_front.sv
// Front end: accepts request items, forms the element product and classifies sizes.
`default_nettype none
module ffha_front (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_hold,
    ffha_req_if.sink      i_req,
    output logic          o_push_valid,
    output ffha_pkg::t_cmd o_push_cmd,
    input  wire           i_push_ready
);

    logic              r_s_valid;
    ffha_pkg::t_op     r_s_op;
    logic [31:0]       r_s_bc;
    logic [63:0]       r_s_prod;
    logic [15:0]       r_s_addr;
    logic              r_s_present;
    logic [31:0]       r_s_wdata;
    logic              accept;
    logic              is_calloc;
    logic [31:0]       n_val;
    logic [32:0]       rounded;

    assign i_req.ready = !i_hold && (!r_s_valid || i_push_ready);
    assign accept      = i_req.valid && i_req.ready;

    // Stage register holds the request and the element product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else begin
            r_s_valid <= accept || (r_s_valid && !i_push_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_op      <= ffha_pkg::t_op'(i_req.opcode);
            r_s_bc      <= i_req.byte_count;
            r_s_prod    <= 64'(i_req.byte_count) * 64'(i_req.element_count);
            r_s_addr    <= i_req.address & 16'hFFFC;
            r_s_present <= i_req.address_present;
            r_s_wdata   <= i_req.write_data;
        end
    end

    // Size classification: rounded need, zero size and product overflow.
    assign is_calloc = (r_s_op == ffha_pkg::OP_CALLOC);
    assign n_val     = is_calloc ? r_s_prod[31:0] : r_s_bc;
    assign rounded   = (33'(n_val) + 33'd7) & ~33'd7;

    always_comb begin
        o_push_cmd.op      = r_s_op;
        o_push_cmd.n       = n_val;
        o_push_cmd.n_zero  = (n_val == 32'd0);
        o_push_cmd.need    = (n_val == 32'd0) ? 33'd8 : rounded;
        o_push_cmd.ovf     = is_calloc && (r_s_prod[63:32] != 32'd0);
        o_push_cmd.addr    = r_s_addr;
        o_push_cmd.present = r_s_present;
        o_push_cmd.wdata   = r_s_wdata;
    end

    assign o_push_valid = r_s_valid;

endmodule
`default_nettype wire

// File: rtl/core/ffha_queue.sv
// Two-entry command queue between the front end and the execution engine.
`default_nettype none
module ffha_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push_valid,
    input  ffha_pkg::t_cmd i_push_cmd,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output ffha_pkg::t_cmd o_pop_cmd,
    input  wire            i_pop
);

    ffha_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_q[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_push_cmd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/ffha_back.sv
// Execution engine: heap memory, free-list sequencer and response register.
`default_nettype none
module ffha_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_cmd_valid,
    input  ffha_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_clearing,
    ffha_rsp_if.source     o_rsp
);

    localparam int AW = ffha_pkg::SPAN_AW;
    localparam int FW = ffha_pkg::FILL_W;

    // Heap memory with a registered read port.
    logic [31:0] r_mem [ffha_pkg::SPAN_WORDS];
    logic [31:0] r_rdq;
    logic        r_rd_oob;
    logic        mem_re;
    logic        mem_we;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;

    // Control state.
    ffha_pkg::t_bstate r_state, n_state, r_ret, n_ret;
    logic [ffha_pkg::HEAD_W-1:0] r_head, n_head;
    logic        r_empty, n_empty;
    logic [ffha_pkg::USED_W-1:0] r_used, n_used;
    logic        r_out_valid, n_out_valid;
    logic [AW-1:0] r_clr, n_clr;

    // Working registers.
    ffha_pkg::t_cmd r_cmd, n_cmd;
    logic [31:0] r_c, n_c, r_sz, n_sz, r_nc, n_nc, r_pc, n_pc;
    logic [31:0] r_pr, n_pr, r_nx, n_nx, r_old, n_old, r_whole, n_whole;
    logic [31:0] r_nd, n_nd, r_base, n_base, r_pay, n_pay, r_arg, n_arg;
    logic [31:0] r_tc, n_tc, r_tsz, n_tsz, r_lold, n_lold, r_fs, n_fs;
    logic [31:0] r_rdata, n_rdata;
    logic [33:0] r_rem, n_rem, r_comb, n_comb;
    logic        r_tbusy, n_tbusy, r_hasnext, n_hasnext, r_grow, n_grow, r_ok, n_ok;
    logic [AW-1:0] r_steps, n_steps;
    logic [FW-1:0] r_k, n_k, r_fq, n_fq;
    logic [1:0]  r_fpart, n_fpart;
    logic [15:0] r_o_addr, n_o_addr;
    logic        r_o_ok, n_o_ok;
    logic [31:0] r_o_data, n_o_data;
    logic [ffha_pkg::USED_W-1:0] r_o_used, n_o_used;

    // Helper values.
    logic [31:0] rdv, rdv_sz, p_addr, nd_less_base, whole_less_base, nx_less4;
    logic [31:0] k_off, q_off, tag_word, fmask, flen;
    logic [33:0] grow_end;
    logic        from_src;

    assign rdv             = r_rd_oob ? 32'd0 : r_rdq;
    assign rdv_sz          = {rdv[31:1], 1'b0};
    assign p_addr          = 32'(r_cmd.addr);
    assign nd_less_base    = r_nd - r_base;
    assign whole_less_base = r_whole - r_base;
    assign nx_less4        = rdv - 32'd4;
    assign k_off           = 32'({r_k, 2'b00});
    assign q_off           = 32'({r_fq, 2'b00});
    assign tag_word        = r_tsz | 32'(r_tbusy);
    assign grow_end        = 34'(r_c) + 34'(ffha_pkg::TAG_BYTES) + 34'(rdv_sz);
    assign from_src        = (r_cmd.op == ffha_pkg::OP_REALLOC);
    assign flen            = (r_cmd.op == ffha_pkg::OP_CALLOC) ? r_cmd.n : r_old;

    // Byte mask for the tail word of a fill.
    always_comb begin
        case (r_fpart)
            2'd1:    fmask = 32'h0000_00FF;
            2'd2:    fmask = 32'h0000_FFFF;
            2'd3:    fmask = 32'h00FF_FFFF;
            default: fmask = 32'h0000_0000;
        endcase
    end

    // Memory port.
    always_ff @(posedge i_clk) begin
        if (mem_we && ffha_pkg::in_span(mem_addr)) begin
            r_mem[mem_addr[AW+1:2]] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdq    <= r_mem[mem_addr[AW+1:2]];
            r_rd_oob <= !ffha_pkg::in_span(mem_addr);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffha_pkg::ST_CLEAR;
            r_head      <= '0;
            r_empty     <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_clr       <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_empty     <= n_empty;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_clr       <= n_clr;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;     r_cmd <= n_cmd;     r_c <= n_c;         r_sz <= n_sz;
        r_nc <= n_nc;       r_pc <= n_pc;       r_pr <= n_pr;       r_nx <= n_nx;
        r_old <= n_old;     r_whole <= n_whole; r_nd <= n_nd;       r_base <= n_base;
        r_pay <= n_pay;     r_arg <= n_arg;     r_tc <= n_tc;       r_tsz <= n_tsz;
        r_lold <= n_lold;   r_fs <= n_fs;       r_rdata <= n_rdata; r_rem <= n_rem;
        r_comb <= n_comb;   r_tbusy <= n_tbusy; r_hasnext <= n_hasnext;
        r_grow <= n_grow;   r_ok <= n_ok;       r_steps <= n_steps; r_k <= n_k;
        r_fq <= n_fq;       r_fpart <= n_fpart; r_o_addr <= n_o_addr;
        r_o_ok <= n_o_ok;   r_o_data <= n_o_data; r_o_used <= n_o_used;
    end

    // Sequencer: next state, memory port and register updates.
    always_comb begin
        n_state = r_state;   n_ret = r_ret;     n_head = r_head;   n_empty = r_empty;
        n_used = r_used;     n_clr = r_clr;     n_cmd = r_cmd;     n_c = r_c;
        n_sz = r_sz;         n_nc = r_nc;       n_pc = r_pc;       n_pr = r_pr;
        n_nx = r_nx;         n_old = r_old;     n_whole = r_whole; n_nd = r_nd;
        n_base = r_base;     n_pay = r_pay;     n_arg = r_arg;     n_tc = r_tc;
        n_tsz = r_tsz;       n_lold = r_lold;   n_fs = r_fs;       n_rdata = r_rdata;
        n_rem = r_rem;       n_comb = r_comb;   n_tbusy = r_tbusy; n_hasnext = r_hasnext;
        n_grow = r_grow;     n_ok = r_ok;       n_steps = r_steps; n_k = r_k;
        n_fq = r_fq;         n_fpart = r_fpart; n_o_addr = r_o_addr;
        n_o_ok = r_o_ok;     n_o_data = r_o_data; n_o_used = r_o_used;
        n_out_valid = r_out_valid && !o_rsp.ready;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = 32'd0;
        mem_wdata = 32'd0;
        o_cmd_pop = 1'b0;

        case (r_state)
            // Lay down the single free chunk after reset.
            ffha_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = 32'({r_clr, 2'b00});
                mem_wdata = (r_clr == '0 || r_clr == AW'(ffha_pkg::SPAN_WORDS - 1))
                            ? ffha_pkg::INIT_TAG : 32'd0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(ffha_pkg::SPAN_WORDS - 1)) begin
                    n_state = ffha_pkg::ST_IDLE;
                end
            end
            ffha_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = ffha_pkg::ST_DECODE;
                end
            end
            ffha_pkg::ST_DECODE: begin
                n_ok    = 1'b0;
                n_pay   = 32'd0;
                n_rdata = 32'd0;
                n_grow  = 1'b0;
                n_state = ffha_pkg::ST_FINISH;
                case (r_cmd.op)
                    ffha_pkg::OP_ALLOC: begin
                        n_state = ffha_pkg::ST_A_START;
                    end
                    ffha_pkg::OP_FREE: begin
                        n_ok = 1'b1;
                        if (r_cmd.present) begin
                            n_state = ffha_pkg::ST_R0;
                        end
                    end
                    ffha_pkg::OP_REALLOC: begin
                        if (!r_cmd.present) begin
                            n_state = ffha_pkg::ST_A_START;
                        end else if (r_cmd.n_zero) begin
                            n_state = ffha_pkg::ST_R0;
                        end else begin
                            n_state = ffha_pkg::ST_Z0;
                        end
                    end
                    ffha_pkg::OP_CALLOC: begin
                        if (!r_cmd.ovf) begin
                            n_state = ffha_pkg::ST_A_START;
                        end
                    end
                    ffha_pkg::OP_LOAD: begin
                        if (r_cmd.present && ffha_pkg::in_span(p_addr)) begin
                            mem_re   = 1'b1;
                            mem_addr = p_addr;
                            n_state  = ffha_pkg::ST_LOAD1;
                        end
                    end
                    ffha_pkg::OP_STORE: begin
                        if (r_cmd.present && ffha_pkg::in_span(p_addr)) begin
                            mem_we    = 1'b1;
                            mem_addr  = p_addr;
                            mem_wdata = r_cmd.wdata;
                            n_ok      = 1'b1;
                        end
                    end
                    default: begin
                        n_state = ffha_pkg::ST_FINISH;
                    end
                endcase
            end
            ffha_pkg::ST_LOAD1: begin
                n_rdata = rdv;
                n_ok    = 1'b1;
                n_state = ffha_pkg::ST_FINISH;
            end

            // First-fit walk of the free list.
            ffha_pkg::ST_A_START: begin
                if (r_cmd.n_zero || r_empty) begin
                    n_state = ffha_pkg::ST_FINISH;
                end else begin
                    n_c     = 32'({r_head, 2'b00});
                    n_steps = '0;
                    n_state = ffha_pkg::ST_A_RDH;
                end
            end
            ffha_pkg::ST_A_RDH: begin
                mem_re   = 1'b1;
                mem_addr = r_c;
                n_state  = ffha_pkg::ST_A_CHK;
            end
            ffha_pkg::ST_A_CHK: begin
                if ({1'b0, rdv_sz} >= r_cmd.need) begin
                    n_whole = rdv_sz;
                    n_nd    = r_cmd.need[31:0];
                    n_rem   = 34'(rdv_sz - r_cmd.need[31:0]);
                    n_base  = 32'd0;
                    n_pay   = r_c + 32'd4;
                    n_arg   = r_c;
                    n_ret   = ffha_pkg::ST_PLACE;
                    n_state = ffha_pkg::ST_LD0;
                end else begin
                    mem_re   = 1'b1;
                    mem_addr = r_c + 32'd8;
                    n_state  = ffha_pkg::ST_A_NXT;
                end
            end
            ffha_pkg::ST_A_NXT: begin
                if (rdv == 32'd0 || r_steps == AW'(ffha_pkg::SPAN_WORDS - 1)) begin
                    n_state = ffha_pkg::ST_FINISH;
                end else begin
                    n_c     = nx_less4;
                    n_steps = r_steps + AW'(1);
                    n_state = ffha_pkg::ST_A_RDH;
                end
            end

            // Mark the chosen chunk in use and split off a large remainder.
            ffha_pkg::ST_PLACE: begin
                n_tc    = r_c;
                n_tbusy = 1'b1;
                n_state = ffha_pkg::ST_PT0;
                if (r_rem >= ffha_pkg::SPLIT_MIN) begin
                    n_tsz  = r_nd;
                    n_used = r_used + nd_less_base[ffha_pkg::USED_W-1:0];
                    n_ret  = ffha_pkg::ST_PLACE2;
                end else begin
                    n_tsz  = r_whole;
                    n_used = r_used + whole_less_base[ffha_pkg::USED_W-1:0];
                    n_ret  = ffha_pkg::ST_POST;
                end
            end
            ffha_pkg::ST_PLACE2: begin
                n_tc    = r_c + ffha_pkg::TAG_BYTES + r_nd;
                n_tsz   = r_rem[31:0] - ffha_pkg::TAG_BYTES;
                n_tbusy = 1'b0;
                n_ret   = ffha_pkg::ST_PLACE3;
                n_state = ffha_pkg::ST_PT0;
            end
            ffha_pkg::ST_PLACE3: begin
                n_arg   = r_c + ffha_pkg::TAG_BYTES + r_nd;
                n_ret   = ffha_pkg::ST_POST;
                n_state = ffha_pkg::ST_LA0;
            end
            ffha_pkg::ST_POST: begin
                n_ok = 1'b1;
                if (!r_grow && (r_cmd.op == ffha_pkg::OP_CALLOC ||
                                (r_cmd.op == ffha_pkg::OP_REALLOC && r_cmd.present))) begin
                    n_state = ffha_pkg::ST_F0;
                end else begin
                    n_state = ffha_pkg::ST_FINISH;
                end
            end

            // Write header and footer tags.
            ffha_pkg::ST_PT0: begin
                mem_we    = 1'b1;
                mem_addr  = r_tc;
                mem_wdata = tag_word;
                n_state   = ffha_pkg::ST_PT1;
            end
            ffha_pkg::ST_PT1: begin
                mem_we    = 1'b1;
                mem_addr  = r_tc + 32'd4 + r_tsz;
                mem_wdata = tag_word;
                n_state   = r_ret;
            end

            // Unlink a chunk from the free list.
            ffha_pkg::ST_LD0: begin
                mem_re   = 1'b1;
                mem_addr = r_arg + 32'd4;
                n_state  = ffha_pkg::ST_LD1;
            end
            ffha_pkg::ST_LD1: begin
                n_pr     = rdv;
                mem_re   = 1'b1;
                mem_addr = r_arg + 32'd8;
                n_state  = ffha_pkg::ST_LD2;
            end
            ffha_pkg::ST_LD2: begin
                n_nx = rdv;
                if (r_pr != 32'd0) begin
                    mem_we    = 1'b1;
                    mem_addr  = r_pr + 32'd4;
                    mem_wdata = rdv;
                end else if (rdv != 32'd0) begin
                    n_head = nx_less4[16:2];
                end else begin
                    n_empty = 1'b1;
                end
                n_state = ffha_pkg::ST_LD3;
            end
            ffha_pkg::ST_LD3: begin
                if (r_nx != 32'd0) begin
                    mem_we    = 1'b1;
                    mem_addr  = r_nx;
                    mem_wdata = r_pr;
                end
                n_state = r_ret;
            end

            // Push a chunk on the head of the free list.
            ffha_pkg::ST_LA0: begin
                n_lold    = r_empty ? 32'd0 : 32'({r_head, 2'b00}) + 32'd4;
                mem_we    = 1'b1;
                mem_addr  = r_arg + 32'd4;
                mem_wdata = 32'd0;
                n_state   = ffha_pkg::ST_LA1;
            end
            ffha_pkg::ST_LA1: begin
                mem_we    = 1'b1;
                mem_addr  = r_arg + 32'd8;
                mem_wdata = r_lold;
                n_state   = ffha_pkg::ST_LA2;
            end
            ffha_pkg::ST_LA2: begin
                if (r_lold != 32'd0) begin
                    mem_we    = 1'b1;
                    mem_addr  = r_lold;
                    mem_wdata = r_arg + 32'd4;
                end
                n_head  = r_arg[16:2];
                n_empty = 1'b0;
                n_state = r_ret;
            end

            // Release with coalescing of both neighbours.
            ffha_pkg::ST_R0: begin
                n_c      = p_addr - 32'd4;
                mem_re   = 1'b1;
                mem_addr = p_addr - 32'd4;
                n_state  = ffha_pkg::ST_R1;
            end
            ffha_pkg::ST_R1: begin
                n_sz     = rdv_sz;
                mem_re   = 1'b1;
                mem_addr = r_c - 32'd4;
                n_state  = ffha_pkg::ST_R2;
            end
            ffha_pkg::ST_R2: begin
                n_pc      = r_c - ffha_pkg::TAG_BYTES - rdv_sz;
                n_nc      = r_c + ffha_pkg::TAG_BYTES + r_sz;
                n_hasnext = (34'(r_c) + 34'(ffha_pkg::TAG_BYTES) + 34'(r_sz))
                            < ffha_pkg::SPAN_BYTES;
                n_used    = r_used - r_sz[ffha_pkg::USED_W-1:0];
                n_state   = ffha_pkg::ST_R3;
            end
            ffha_pkg::ST_R3: begin
                if (r_hasnext) begin
                    mem_re   = 1'b1;
                    mem_addr = r_nc;
                    n_state  = ffha_pkg::ST_R4;
                end else begin
                    n_state = ffha_pkg::ST_R6;
                end
            end
            ffha_pkg::ST_R4: begin
                if (!rdv[0]) begin
                    n_arg   = r_nc;
                    n_ret   = ffha_pkg::ST_R5;
                    n_state = ffha_pkg::ST_LD0;
                end else begin
                    n_state = ffha_pkg::ST_R6;
                end
            end
            ffha_pkg::ST_R5: begin
                mem_re   = 1'b1;
                mem_addr = r_nc;
                n_state  = ffha_pkg::ST_R5B;
            end
            ffha_pkg::ST_R5B: begin
                n_sz    = r_sz + ffha_pkg::TAG_BYTES + rdv_sz;
                n_state = ffha_pkg::ST_R6;
            end
            ffha_pkg::ST_R6: begin
                if (r_c != 32'd0) begin
                    mem_re   = 1'b1;
                    mem_addr = r_pc;
                    n_state  = ffha_pkg::ST_R7;
                end else begin
                    n_state = ffha_pkg::ST_R9;
                end
            end
            ffha_pkg::ST_R7: begin
                if (!rdv[0]) begin
                    n_arg   = r_pc;
                    n_ret   = ffha_pkg::ST_R8;
                    n_state = ffha_pkg::ST_LD0;
                end else begin
                    n_state = ffha_pkg::ST_R9;
                end
            end
            ffha_pkg::ST_R8: begin
                mem_re   = 1'b1;
                mem_addr = r_pc;
                n_state  = ffha_pkg::ST_R8B;
            end
            ffha_pkg::ST_R8B: begin
                n_sz    = r_sz + ffha_pkg::TAG_BYTES + rdv_sz;
                n_c     = r_pc;
                n_state = ffha_pkg::ST_R9;
            end
            ffha_pkg::ST_R9: begin
                n_tc    = r_c;
                n_tsz   = r_sz;
                n_tbusy = 1'b0;
                n_ret   = ffha_pkg::ST_R10;
                n_state = ffha_pkg::ST_PT0;
            end
            ffha_pkg::ST_R10: begin
                n_arg   = r_c;
                n_ret   = ffha_pkg::ST_FINISH;
                n_state = ffha_pkg::ST_LA0;
            end

            // Resize: keep, grow in place, or fall back to a fresh allocation.
            ffha_pkg::ST_Z0: begin
                n_c      = p_addr - 32'd4;
                mem_re   = 1'b1;
                mem_addr = p_addr - 32'd4;
                n_state  = ffha_pkg::ST_Z1;
            end
            ffha_pkg::ST_Z1: begin
                n_old = rdv_sz;
                n_nc  = grow_end[31:0];
                if (r_cmd.need <= {1'b0, rdv_sz}) begin
                    n_pay   = p_addr;
                    n_ok    = 1'b1;
                    n_state = ffha_pkg::ST_FINISH;
                end else if (grow_end < ffha_pkg::SPAN_BYTES) begin
                    mem_re   = 1'b1;
                    mem_addr = grow_end[31:0];
                    n_state  = ffha_pkg::ST_Z2;
                end else begin
                    n_state = ffha_pkg::ST_A_START;
                end
            end
            ffha_pkg::ST_Z2: begin
                if (!rdv[0]) begin
                    n_comb  = 34'(r_old) + 34'(ffha_pkg::TAG_BYTES) + 34'(rdv_sz);
                    n_state = ffha_pkg::ST_Z3;
                end else begin
                    n_state = ffha_pkg::ST_A_START;
                end
            end
            ffha_pkg::ST_Z3: begin
                if (r_comb >= 34'(r_cmd.need)) begin
                    n_rem   = r_comb - 34'(r_cmd.need);
                    n_whole = r_comb[31:0];
                    n_nd    = r_cmd.need[31:0];
                    n_base  = r_old;
                    n_pay   = p_addr;
                    n_grow  = 1'b1;
                    n_arg   = r_nc;
                    n_ret   = ffha_pkg::ST_PLACE;
                    n_state = ffha_pkg::ST_LD0;
                end else begin
                    n_state = ffha_pkg::ST_A_START;
                end
            end

            // Copy or clear payload words, then the partial tail word.
            ffha_pkg::ST_F0: begin
                if (flen[31:2] > 30'(ffha_pkg::SPAN_WORDS)) begin
                    n_fq    = FW'(ffha_pkg::SPAN_WORDS);
                    n_fpart = 2'd0;
                end else begin
                    n_fq    = flen[FW+1:2];
                    n_fpart = flen[1:0];
                end
                n_k     = '0;
                n_state = ffha_pkg::ST_F1;
            end
            ffha_pkg::ST_F1: begin
                if (r_k == r_fq) begin
                    n_state = ffha_pkg::ST_FP0;
                end else if (from_src) begin
                    mem_re   = 1'b1;
                    mem_addr = p_addr + k_off;
                    n_state  = ffha_pkg::ST_F2;
                end else begin
                    mem_we    = 1'b1;
                    mem_addr  = r_pay + k_off;
                    mem_wdata = 32'd0;
                    n_k       = r_k + FW'(1);
                end
            end
            ffha_pkg::ST_F2: begin
                mem_we    = 1'b1;
                mem_addr  = r_pay + k_off;
                mem_wdata = rdv;
                n_k       = r_k + FW'(1);
                n_state   = ffha_pkg::ST_F1;
            end
            ffha_pkg::ST_FP0: begin
                if (r_fpart == 2'd0) begin
                    n_state = ffha_pkg::ST_FEND;
                end else if (from_src) begin
                    mem_re   = 1'b1;
                    mem_addr = p_addr + q_off;
                    n_state  = ffha_pkg::ST_FP1;
                end else begin
                    n_fs     = 32'd0;
                    mem_re   = 1'b1;
                    mem_addr = r_pay + q_off;
                    n_state  = ffha_pkg::ST_FP2;
                end
            end
            ffha_pkg::ST_FP1: begin
                n_fs     = rdv;
                mem_re   = 1'b1;
                mem_addr = r_pay + q_off;
                n_state  = ffha_pkg::ST_FP2;
            end
            ffha_pkg::ST_FP2: begin
                mem_we    = 1'b1;
                mem_addr  = r_pay + q_off;
                mem_wdata = (rdv & ~fmask) | (r_fs & fmask);
                n_state   = ffha_pkg::ST_FEND;
            end
            ffha_pkg::ST_FEND: begin
                n_state = from_src ? ffha_pkg::ST_R0 : ffha_pkg::ST_FINISH;
            end

            // Load the response register once it is free.
            ffha_pkg::ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_o_ok      = r_ok;
                    n_o_data    = r_rdata;
                    n_o_used    = r_used;
                    n_o_addr    = (r_ok && (r_cmd.op == ffha_pkg::OP_ALLOC ||
                                            r_cmd.op == ffha_pkg::OP_REALLOC ||
                                            r_cmd.op == ffha_pkg::OP_CALLOC))
                                  ? r_pay[15:0] : 16'd0;
                    n_state     = ffha_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ffha_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_clearing           = (r_state == ffha_pkg::ST_CLEAR);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_address = r_o_addr;
    assign o_rsp.success        = r_o_ok;
    assign o_rsp.read_data      = r_o_data;
    assign o_rsp.bytes_in_use   = r_o_used;

endmodule
`default_nettype wire

// File: rtl/core/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: front end, command queue and engine.
// Zeroed allocate clears the payload word by word, a moving reallocate copies it word by word.
// Items run one at a time in the engine; the front stage and queue hold three more meanwhile.
// Reset: synchronous, active low; a clearing pass then rebuilds the heap.
`default_nettype none
module first_fit_heap_allocator (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ffha_req_if.sink   i_req,
    ffha_rsp_if.source o_rsp
);

    logic           push_valid;
    logic           push_ready;
    ffha_pkg::t_cmd push_cmd;
    logic           cmd_valid;
    ffha_pkg::t_cmd cmd;
    logic           cmd_pop;
    logic           clearing;

    ffha_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hold       (clearing),
        .i_req        (i_req),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    ffha_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (cmd_valid),
        .o_pop_cmd    (cmd),
        .i_pop        (cmd_pop)
    );

    ffha_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_clearing  (clearing),
        .o_rsp       (o_rsp)
    );

    // No request is taken while the heap is being rebuilt.
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !(i_req.valid && i_req.ready))
        else $error("request accepted during clearing pass");

    // The engine only pops a command the queue holds.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("engine popped an empty queue");

    // Reset always starts the clearing pass.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> clearing)
        else $error("clearing pass did not start after reset");

endmodule
`default_nettype wire

// File: verif/tb_first_fit_heap_allocator.sv
// Self-checking testbench of the first-fit heap allocator, with its own heap predictor.
`timescale 1ns / 100ps
module tb_first_fit_heap_allocator;

    localparam int CYCLE_LIMIT = 6000000;

    // One request item and one response item as the testbench sees them.
    typedef struct {
        bit [2:0]  opcode;
        bit [31:0] byte_count;
        bit [31:0] element_count;
        bit [15:0] address;
        bit        present;
        bit [31:0] write_data;
    } t_heap_req;

    typedef struct {
        bit [15:0] result_address;
        bit        success;
        bit [31:0] read_data;
        bit [16:0] bytes_in_use;
    } t_heap_rsp;

    localparam bit [2:0] OP_BAD_LO = 3'd6;
    localparam bit [2:0] OP_BAD_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ffha_req_if req ();
    ffha_rsp_if rsp ();

    first_fit_heap_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always #1 i_clk = ~i_clk;

    // Predicted heap image and allocator state.
    bit [31:0] heap_mem [0:ffha_pkg::SPAN_WORDS-1];
    bit [14:0] list_head;
    bit        list_empty;
    bit [16:0] used_bytes_pred;

    t_heap_rsp expected_rsps [$];
    int unsigned fail_count;
    int unsigned checked_count;
    int unsigned alloc_ok_count;
    bit          idle_on;
    bit          hold_request;
    int unsigned cycle_count;

    // Blocks that the stimulus currently owns: payload offset and requested size.
    bit [15:0]   live_addr [$];
    int unsigned live_size [$];

    // Word access with the span rule: reads beyond give zero, writes beyond are lost.
    function automatic bit [31:0] heap_rd(bit [31:0] b);
        bit [31:0] w;
        w = b >> 2;
        return (w < ffha_pkg::SPAN_WORDS) ? heap_mem[w] : 32'd0;
    endfunction

    function automatic void heap_wr(bit [31:0] b, bit [31:0] v);
        bit [31:0] w;
        w = b >> 2;
        if (w < ffha_pkg::SPAN_WORDS) heap_mem[w] = v;
    endfunction

    function automatic bit [31:0] payload_bytes(bit [31:0] c);
        return heap_rd(c) & ~32'd1;
    endfunction

    function automatic bit tag_busy(bit [31:0] c);
        bit [31:0] t;
        t = heap_rd(c);
        return t[0];
    endfunction

    function automatic void write_tags(bit [31:0] c, bit [31:0] size, bit busy);
        bit [31:0] t;
        t = size | {31'd0, busy};
        heap_wr(c, t);
        heap_wr(c + 32'd4 + size, t);
    endfunction

    // Free list: push at the head, unlink anywhere.
    function automatic void list_push(bit [31:0] c);
        bit [31:0] p, old;
        p = c + 32'd4;
        old = list_empty ? 32'd0 : (32'(list_head) << 2) + 32'd4;
        heap_wr(p, 32'd0);
        heap_wr(p + 32'd4, old);
        if (old != 0) heap_wr(old, p);
        list_head = c[16:2];
        list_empty = 1'b0;
    endfunction

    function automatic void list_unlink(bit [31:0] c);
        bit [31:0] p, pr, nx, t;
        p = c + 32'd4;
        pr = heap_rd(p);
        nx = heap_rd(p + 32'd4);
        t = nx - 32'd4;
        if (pr != 0) heap_wr(pr + 32'd4, nx);
        else if (nx != 0) list_head = t[16:2];
        else list_empty = 1'b1;
        if (nx != 0) heap_wr(nx, pr);
    endfunction

    function automatic bit [63:0] rounded_need(bit [63:0] n);
        bit [63:0] r;
        r = (n + 64'd7) & ~64'd7;
        return (r < 64'd8) ? 64'd8 : r;
    endfunction

    // First fit over the free list, splitting when the remainder is worth keeping.
    function automatic bit first_fit(bit [63:0] n, output bit [31:0] pay);
        bit [63:0] need;
        bit [31:0] c, sz, nx, nd, rem;
        pay = 32'd0;
        if (n == 0 || list_empty) return 1'b0;
        need = rounded_need(n);
        c = 32'(list_head) << 2;
        for (int steps = 0; steps < ffha_pkg::SPAN_WORDS; steps++) begin
            sz = payload_bytes(c);
            if ({32'd0, sz} >= need) begin
                nd = need[31:0];
                rem = sz - nd;
                list_unlink(c);
                if (rem >= 32'd16) begin
                    write_tags(c, nd, 1'b1);
                    used_bytes_pred += nd[16:0];
                    write_tags(c + 32'd8 + nd, rem - 32'd8, 1'b0);
                    list_push(c + 32'd8 + nd);
                end else begin
                    write_tags(c, sz, 1'b1);
                    used_bytes_pred += sz[16:0];
                end
                pay = c + 32'd4;
                return 1'b1;
            end
            nx = heap_rd(c + 32'd8);
            if (nx == 0) return 1'b0;
            c = nx - 32'd4;
        end
        return 1'b0;
    endfunction

    // Release a chunk and merge it with free physical neighbours.
    function automatic void release_chunk(bit [31:0] p);
        bit [31:0] c, sz, nc, pc;
        bit has_next, has_prev;
        c = p - 32'd4;
        sz = payload_bytes(c);
        has_next = (64'(c) + 64'd8 + 64'(sz)) < 64'(ffha_pkg::SPAN_WORDS * 4);
        nc = c + 32'd8 + sz;
        has_prev = (c > 0);
        pc = c - 32'd8 - (heap_rd(c - 32'd4) & ~32'd1);
        used_bytes_pred -= sz[16:0];
        if (has_next && !tag_busy(nc)) begin
            list_unlink(nc);
            sz += 32'd8 + payload_bytes(nc);
        end
        if (has_prev && !tag_busy(pc)) begin
            list_unlink(pc);
            sz += 32'd8 + payload_bytes(pc);
            c = pc;
        end
        write_tags(c, sz, 1'b0);
        list_push(c);
    endfunction

    // Copy or clear len bytes, keeping the untouched bytes of a partial last word.
    function automatic void copy_bytes(bit [31:0] dst, bit [31:0] src, bit from_src,
                                       bit [31:0] len);
        bit [31:0] q, part, m, s;
        q = len >> 2;
        part = len & 32'd3;
        if (q > ffha_pkg::SPAN_WORDS) begin
            q = ffha_pkg::SPAN_WORDS;
            part = 0;
        end
        for (bit [31:0] k = 0; k < q; k++)
            heap_wr(dst + 32'd4 * k, from_src ? heap_rd(src + 32'd4 * k) : 32'd0);
        if (part != 0) begin
            m = (32'd1 << (8 * part)) - 32'd1;
            s = from_src ? heap_rd(src + 32'd4 * q) : 32'd0;
            heap_wr(dst + 32'd4 * q, (heap_rd(dst + 32'd4 * q) & ~m) | (s & m));
        end
    endfunction

    // Keep, grow in place, or move.
    function automatic bit resize_chunk(bit [31:0] p, bit [63:0] n, output bit [31:0] pay);
        bit [31:0] c, old, nc, np, nd;
        bit [63:0] need, comb, rem;
        c = p - 32'd4;
        old = payload_bytes(c);
        need = rounded_need(n);
        pay = 32'd0;
        if (need <= 64'(old)) begin
            pay = p;
            return 1'b1;
        end
        if ((64'(c) + 64'd8 + 64'(old)) < 64'(ffha_pkg::SPAN_WORDS * 4)) begin
            nc = c + 32'd8 + old;
            if (!tag_busy(nc)) begin
                comb = 64'(old) + 64'd8 + 64'(payload_bytes(nc));
                if (comb >= need) begin
                    rem = comb - need;
                    list_unlink(nc);
                    if (rem >= 64'd16) begin
                        nd = need[31:0];
                        write_tags(c, nd, 1'b1);
                        used_bytes_pred += 17'(nd - old);
                        write_tags(c + 32'd8 + nd, rem[31:0] - 32'd8, 1'b0);
                        list_push(c + 32'd8 + nd);
                    end else begin
                        write_tags(c, comb[31:0], 1'b1);
                        used_bytes_pred += 17'(comb[31:0] - old);
                    end
                    pay = p;
                    return 1'b1;
                end
            end
        end
        if (!first_fit(n, np)) return 1'b0;
        copy_bytes(np, p, 1'b1, old);
        release_chunk(p);
        pay = np;
        return 1'b1;
    endfunction

    function automatic void heap_reset_pred();
        foreach (heap_mem[i]) heap_mem[i] = 32'd0;
        list_empty = 1'b1;
        list_head = '0;
        used_bytes_pred = '0;
        write_tags(32'd0, 32'(ffha_pkg::SPAN_WORDS * 4 - 8), 1'b0);
        list_push(32'd0);
    endfunction

    // Apply one accepted request to the predicted heap and return its response.
    function automatic t_heap_rsp predict_heap_op(t_heap_req r);
        t_heap_rsp e;
        bit [31:0] a, pay;
        bit [63:0] total;
        bit ok;
        e = '{default: 0};
        a = {16'd0, r.address[15:2], 2'b00};
        pay = 32'd0;
        ok = 1'b0;
        case (r.opcode)
            ffha_pkg::OP_ALLOC: ok = first_fit(64'(r.byte_count), pay);
            ffha_pkg::OP_FREE: begin
                if (r.present) release_chunk(a);
                ok = 1'b1;
            end
            ffha_pkg::OP_REALLOC: begin
                if (!r.present) ok = first_fit(64'(r.byte_count), pay);
                else if (r.byte_count == 0) release_chunk(a);
                else ok = resize_chunk(a, 64'(r.byte_count), pay);
            end
            ffha_pkg::OP_CALLOC: begin
                total = 64'(r.byte_count) * 64'(r.element_count);
                if (total <= 64'hFFFF_FFFF && first_fit(total, pay)) begin
                    copy_bytes(pay, 32'd0, 1'b0, total[31:0]);
                    ok = 1'b1;
                end
            end
            ffha_pkg::OP_LOAD: begin
                if (r.present && (a >> 2) < ffha_pkg::SPAN_WORDS) begin
                    e.read_data = heap_mem[a >> 2];
                    ok = 1'b1;
                end
            end
            ffha_pkg::OP_STORE: begin
                if (r.present && (a >> 2) < ffha_pkg::SPAN_WORDS) begin
                    heap_mem[a >> 2] = r.write_data;
                    ok = 1'b1;
                end
            end
            default: ;
        endcase
        if (ok && (r.opcode == ffha_pkg::OP_ALLOC || r.opcode == ffha_pkg::OP_REALLOC ||
                   r.opcode == ffha_pkg::OP_CALLOC))
            e.result_address = pay[15:0];
        e.success = ok;
        e.bytes_in_use = used_bytes_pred;
        return e;
    endfunction

    // Cycle counter and overall time limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_first_fit_heap_allocator: FAIL");
            $finish;
        end
    end

    // Response side: random stall bursts and one long hold on request.
    initial begin
        int unsigned hold;
        hold = 0;
        rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold = 400;
            end else if (hold == 0 && idle_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 4);
            end
            if (hold != 0) begin
                rsp.ready = 1'b0;
                hold--;
            end else begin
                rsp.ready = 1'b1;
            end
        end
    end

    // Compare every accepted response with the oldest prediction.
    always @(posedge i_clk) begin
        t_heap_rsp e;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
                $error("unexpected response item: result_address %h", rsp.result_address);
                fail_count++;
            end else begin
                e = expected_rsps.pop_front();
                checked_count++;
                if (rsp.result_address !== e.result_address) begin
                    $error("result_address: expected %h, got %h",
                           e.result_address, rsp.result_address);
                    fail_count++;
                end
                if (rsp.success !== e.success) begin
                    $error("success: expected %b, got %b", e.success, rsp.success);
                    fail_count++;
                end
                if (rsp.read_data !== e.read_data) begin
                    $error("read_data: expected %h, got %h", e.read_data, rsp.read_data);
                    fail_count++;
                end
                if (rsp.bytes_in_use !== e.bytes_in_use) begin
                    $error("bytes_in_use: expected %h, got %h",
                           e.bytes_in_use, rsp.bytes_in_use);
                    fail_count++;
                end
            end
        end
    end

    // Offer one item, wait for it to be taken and record what it should produce.
    task automatic send_item(input t_heap_req r, output t_heap_rsp e);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                req.valid = 1'b0;
            end
        end
        @(negedge i_clk);
        req.valid = 1'b1;
        req.opcode = r.opcode;
        req.byte_count = r.byte_count;
        req.element_count = r.element_count;
        req.address = r.address;
        req.address_present = r.present;
        req.write_data = r.write_data;
        do @(posedge i_clk); while (!req.ready);
        e = predict_heap_op(r);
        expected_rsps.push_back(e);
        if (e.success && (r.opcode == ffha_pkg::OP_ALLOC || r.opcode == ffha_pkg::OP_CALLOC))
            alloc_ok_count++;
    endtask

    task automatic wait_all_responses();
        @(negedge i_clk);
        req.valid = 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_heap_req make_req(bit [2:0] op, bit [31:0] bc = 0,
                                           bit [31:0] ec = 0, bit [15:0] a = 0,
                                           bit pres = 0, bit [31:0] wd = 0);
        t_heap_req r;
        r.opcode = op;
        r.byte_count = bc;
        r.element_count = ec;
        r.address = a;
        r.present = pres;
        r.write_data = wd;
        return r;
    endfunction

    // Send an item and keep the list of owned blocks in step with the prediction.
    task automatic run_tracked(input t_heap_req r, input int idx);
        t_heap_rsp e;
        send_item(r, e);
        case (r.opcode)
            ffha_pkg::OP_ALLOC, ffha_pkg::OP_CALLOC: begin
                if (e.success) begin
                    live_addr.push_back(e.result_address);
                    live_size.push_back(r.opcode == ffha_pkg::OP_ALLOC ? r.byte_count
                                        : r.byte_count * r.element_count);
                end
            end
            ffha_pkg::OP_FREE: if (idx >= 0) begin
                live_addr.delete(idx);
                live_size.delete(idx);
            end
            ffha_pkg::OP_REALLOC: begin
                if (idx < 0) begin
                    if (e.success) begin
                        live_addr.push_back(e.result_address);
                        live_size.push_back(r.byte_count);
                    end
                end else if (r.byte_count == 0) begin
                    live_addr.delete(idx);
                    live_size.delete(idx);
                end else if (e.success) begin
                    live_addr[idx] = e.result_address;
                    live_size[idx] = r.byte_count;
                end
            end
            default: ;
        endcase
    endtask

    function automatic bit [15:0] live_word(int idx);
        int unsigned words;
        words = (live_size[idx] + 3) / 4;
        if (words == 0) words = 1;
        return live_addr[idx] + 16'(4 * $urandom_range(0, words - 1));
    endfunction

    // Edge sizes, every operation and each special case once.
    task automatic test_directed();
        run_tracked(make_req(ffha_pkg::OP_ALLOC, 0), -1);
        run_tracked(make_req(ffha_pkg::OP_ALLOC, 32'hFFFF_FFFF), -1);
        run_tracked(make_req(ffha_pkg::OP_ALLOC, 32'hFFFF_FFF9), -1);
        run_tracked(make_req(ffha_pkg::OP_ALLOC, 32'(ffha_pkg::SPAN_WORDS * 4 - 8)), -1);
        run_tracked(make_req(ffha_pkg::OP_ALLOC, 1), -1);
        run_tracked(make_req(ffha_pkg::OP_FREE, 0, 0, live_addr[0] | 16'd3, 1), 0);
        run_tracked(make_req(ffha_pkg::OP_ALLOC, 1), -1);
        run_tracked(make_req(ffha_pkg::OP_ALLOC, 8), -1);
        run_tracked(make_req(ffha_pkg::OP_ALLOC, 20), -1);
        run_tracked(make_req(ffha_pkg::OP_STORE, 0, 0, live_addr[0], 1, 32'hA5A5_5A5A), -1);
        run_tracked(make_req(ffha_pkg::OP_LOAD, 0, 0, live_addr[0], 1), -1);
        run_tracked(make_req(ffha_pkg::OP_LOAD, 0, 0, 16'hFFFF, 0), -1);
        run_tracked(make_req(ffha_pkg::OP_STORE, 0, 0, 16'h0010, 0, 32'hFFFF_FFFF), -1);
        run_tracked(make_req(ffha_pkg::OP_FREE), -1);
        run_tracked(make_req(OP_BAD_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1,
                             32'hFFFF_FFFF), -1);
        run_tracked(make_req(OP_BAD_HI, 5, 5, 16'h0004, 1, 32'h1), -1);
        run_tracked(make_req(ffha_pkg::OP_REALLOC, 12), -1);
        // Keep in place, grow into the free space that follows, then move.
        run_tracked(make_req(ffha_pkg::OP_REALLOC, 4, 0, live_addr[0], 1), 0);
        run_tracked(make_req(ffha_pkg::OP_REALLOC, 64, 0, live_addr[3], 1), 3);
        run_tracked(make_req(ffha_pkg::OP_REALLOC, 40, 0, live_addr[0], 1), 0);
        run_tracked(make_req(ffha_pkg::OP_REALLOC, 0, 0, live_addr[1], 1), 1);
        run_tracked(make_req(ffha_pkg::OP_CALLOC, 32'h0001_0000, 32'h0001_0000), -1);
        run_tracked(make_req(ffha_pkg::OP_CALLOC, 0, 32'hFFFF_FFFF), -1);
        run_tracked(make_req(ffha_pkg::OP_CALLOC, 3, 5), -1);
        run_tracked(make_req(ffha_pkg::OP_REALLOC, 32'hFFFF_FFF0, 0, live_addr[0], 1), 0);
    endtask

    // One random item, mostly well formed against the blocks owned.
    task automatic random_item(input bit wild);
        int unsigned pick;
        int idx;
        bit [31:0] sz;
        pick = $urandom_range(0, 99);
        idx = (live_addr.size() != 0) ? $urandom_range(0, live_addr.size() - 1) : -1;
        if (live_addr.size() > 40 && pick < 40) pick = 35;
        case ($urandom_range(0, 19))
            0: sz = $urandom();
            1, 2: sz = $urandom_range(129, 4096);
            default: sz = $urandom_range(1, 128);
        endcase
        if (wild) begin
            case ($urandom_range(0, 2))
                0: run_tracked(make_req(ffha_pkg::OP_FREE, 0, 0, 16'($urandom()), 1), -1);
                1: run_tracked(make_req(ffha_pkg::OP_STORE, 0, 0, 16'($urandom()), 1,
                                        $urandom()), -1);
                default: run_tracked(make_req(ffha_pkg::OP_REALLOC, sz, 0, 16'($urandom()),
                                              1), -1);
            endcase
        end else if (pick < 30 || idx < 0) begin
            run_tracked(make_req(ffha_pkg::OP_ALLOC, sz, $urandom(), 16'($urandom()),
                                 1'($urandom())), -1);
        end else if (pick < 52) begin
            run_tracked(make_req(ffha_pkg::OP_FREE, $urandom(), 0,
                                 live_addr[idx] | 16'($urandom_range(0, 3)), 1), idx);
        end else if (pick < 66) begin
            case ($urandom_range(0, 9))
                0: run_tracked(make_req(ffha_pkg::OP_REALLOC, sz), -1);
                1: run_tracked(make_req(ffha_pkg::OP_REALLOC, 0, 0, live_addr[idx], 1), idx);
                default: run_tracked(make_req(ffha_pkg::OP_REALLOC, sz, 0, live_addr[idx], 1),
                                     idx);
            endcase
        end else if (pick < 74) begin
            if ($urandom_range(0, 4) == 0)
                run_tracked(make_req(ffha_pkg::OP_CALLOC, $urandom(), $urandom()), -1);
            else
                run_tracked(make_req(ffha_pkg::OP_CALLOC, $urandom_range(1, 16),
                                     $urandom_range(1, 16)), -1);
        end else if (pick < 86) begin
            if ($urandom_range(0, 9) == 0)
                run_tracked(make_req(ffha_pkg::OP_LOAD, 0, 0, 16'($urandom()),
                                     1'($urandom())), -1);
            else
                run_tracked(make_req(ffha_pkg::OP_LOAD, 0, 0, live_word(idx), 1), -1);
        end else if (pick < 98) begin
            run_tracked(make_req(ffha_pkg::OP_STORE, $urandom(), 0, live_word(idx), 1,
                                 $urandom()), -1);
        end else begin
            run_tracked(make_req(pick[0] ? OP_BAD_HI : OP_BAD_LO, $urandom(), $urandom(),
                                 16'($urandom()), 1, $urandom()), -1);
        end
    endtask

    // Random traffic with idling, one long response hold and one full drain.
    task automatic test_random_traffic();
        idle_on = 1'b1;
        for (int i = 0; i < 1050; i++) begin
            if (i == 400) hold_request = 1'b1;
            if (i == 700) wait_all_responses();
            random_item(1'b0);
        end
    endtask

    // Back-to-back traffic, then addresses that were never handed out.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        for (int i = 0; i < 160; i++) random_item(1'b0);
    endtask

    task automatic test_wild_addresses();
        for (int i = 0; i < 12; i++) random_item(1'b1);
        for (int i = 0; i < 8; i++)
            run_tracked(make_req(ffha_pkg::OP_LOAD, 0, 0, 16'($urandom()), 1), -1);
    endtask

    initial begin
        fail_count = 0;
        checked_count = 0;
        alloc_ok_count = 0;
        cycle_count = 0;
        idle_on = 1'b0;
        hold_request = 1'b0;
        req.valid = 1'b0;
        req.opcode = '0;
        req.byte_count = '0;
        req.element_count = '0;
        req.address = '0;
        req.address_present = 1'b0;
        req.write_data = '0;
        heap_reset_pred();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_traffic();
        test_back_to_back();
        test_wild_addresses();

        wait_all_responses();
        repeat (200) @(posedge i_clk);
        $display("Checked %0d responses, %0d successful allocations, blocks still held: %0d.",
                 checked_count, alloc_ok_count, live_addr.size());
        $display("Covered all operations, stalls on both sides and unowned addresses.");
        if (fail_count == 0 && expected_rsps.size() == 0)
            $display("tb_first_fit_heap_allocator: PASS");
        else
            $display("tb_first_fit_heap_allocator: FAIL");
        $finish;
    end

endmodule

// File: first_fit_heap_allocator.f
rtl/core/ffha_pkg.sv
rtl/core/ffha_req_if.sv
rtl/core/ffha_rsp_if.sv
rtl/core/ffha_front.sv
rtl/core/ffha_queue.sv
rtl/core/ffha_back.sv
rtl/core/first_fit_heap_allocator.sv
verif/tb_first_fit_heap_allocator.sv
